// ===== rtl/ipv4rf_pkg.sv =====
package ipv4rf_pkg;

   localparam int HANDLER_SLOTS = 4;
   localparam int HEADER_BYTES  = 20;
   localparam int IP_VERSION    = 4;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   typedef enum logic [2:0] {
      ST_DELIVERED    = 3'd0,
      ST_TOO_SHORT    = 3'd1,
      ST_BAD_VERSION  = 3'd2,
      ST_NOT_LOCAL    = 3'd3,
      ST_BAD_CHECKSUM = 3'd4,
      ST_BAD_LENGTH   = 3'd5,
      ST_TRUNCATED    = 3'd6,
      ST_NO_HANDLER   = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      CSR_LOCAL_ADDR     = 2'd0,
      CSR_HANDLER_PROTOS = 2'd1,
      CSR_HANDLER_COUNT  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                     kind;
      logic [7:0]               payload_byte;
      logic [HANDLER_SLOTS-1:0] handler_mask;
      logic                     payload_last;
      status_type               status;
   } result_type;

   // up to two results per item; a lone result always sits in first
   typedef struct packed {
      logic       first_valid;
      logic       second_valid;
      result_type first;
      result_type second;
   } push_type;

endpackage

// ===== rtl/ipv4_receive_filter.sv =====
// An accepted byte's results are registered into the result queue and offered on rsp_ in order behind earlier results.
// Throughput: one byte per cycle while req_stall is low; header checks and sums are updated as each byte is taken.
// A frame-end byte that is also payload gives two items, which leave one per cycle while rsp_stall is low
// from a four-entry result queue; req_stall rises while fewer than two entries are free.
// Reset (synchronous, active high) clears registers, frame state and the result queue.
module ipv4_receive_filter
   import ipv4rf_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_data_byte,
   input  logic                     req_frame_last,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_kind,
   output logic [7:0]               rsp_payload_byte,
   output logic [HANDLER_SLOTS-1:0] rsp_handler_mask,
   output logic                     rsp_payload_last,
   output logic [2:0]               rsp_status,
   input  logic                     csr_write,
   input  logic [1:0]               csr_index,
   input  logic [31:0]              csr_data
);

   logic [31:0] local_addr_ff;
   logic [31:0] protos_ff;
   logic [2:0]  hcount_ff;
   logic        room;
   logic        in_take;
   logic        out_take;
   push_type    push;
   result_type  out_res;

   assign in_take   = req_valid && !req_stall;
   assign req_stall = !room;
   assign out_take  = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         local_addr_ff <= '0;
         protos_ff     <= '0;
         hcount_ff     <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_LOCAL_ADDR:     local_addr_ff <= csr_data;
            CSR_HANDLER_PROTOS: protos_ff     <= csr_data;
            CSR_HANDLER_COUNT:  hcount_ff     <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   ipv4rf_parse u_parse (
      .clock             (clock),
      .reset             (reset),
      .in_take           (in_take),
      .data_byte         (req_data_byte),
      .frame_last        (req_frame_last),
      .local_address     (local_addr_ff),
      .handler_protocols (protos_ff),
      .slots_used        (hcount_ff),
      .push              (push)
   );

   ipv4rf_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_valid),
      .out_take  (out_take),
      .out_res   (out_res)
   );

   assign rsp_kind         = out_res.kind;
   assign rsp_payload_byte = out_res.payload_byte;
   assign rsp_handler_mask = out_res.handler_mask;
   assign rsp_payload_last = out_res.payload_last;
   assign rsp_status       = out_res.status;

endmodule

// ===== rtl/ipv4rf_parse.sv =====
module ipv4rf_parse
   import ipv4rf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_take,
   input  logic [7:0]  data_byte,
   input  logic        frame_last,
   input  logic [31:0] local_address,
   input  logic [31:0] handler_protocols,
   input  logic [2:0]  slots_used,
   output push_type    push
);

   localparam logic [15:0] HDR_LEN = 16'(HEADER_BYTES);
   localparam logic [15:0] POS_MAX = 16'hFFFF;

   logic [15:0]              pos_ff, pos_in;
   logic [15:0]              sum_ff, sum_in;
   logic [7:0]               hi_ff, hi_in;
   logic [15:0]              tlen_ff, tlen_in;
   logic [7:0]               proto_ff, proto_in;
   logic                     ver_ff, ver_in;
   logic                     dest_ff, dest_in;
   logic [HANDLER_SLOTS-1:0] mask_ff, mask_in;

   logic                     in_hdr;
   logic [16:0]              word_sum;
   logic [7:0]               want;
   logic                     dest_eq;
   logic [HANDLER_SLOTS-1:0] new_mask;
   logic                     hdr_ok;
   logic                     is_payload;
   logic [16:0]              count;
   status_type               status;
   result_type               pay_res, stat_res;

   always_comb begin
      for (int i = 0; i < HANDLER_SLOTS; i++) begin
         new_mask[i] = (3'(i) < slots_used) &&
                       (handler_protocols[8*i +: 8] == proto_ff);
      end
   end

   always_comb begin
      in_hdr   = pos_ff < HDR_LEN;
      word_sum = {1'b0, sum_ff} + {1'b0, hi_ff, data_byte};
      // destination byte 16 maps to address bits 31:24
      want     = local_address[8*(3 - int'(pos_ff[1:0])) +: 8];
      dest_eq  = want == data_byte;

      pos_in   = pos_ff;
      sum_in   = sum_ff;
      hi_in    = hi_ff;
      tlen_in  = tlen_ff;
      proto_in = proto_ff;
      ver_in   = ver_ff;
      dest_in  = dest_ff;
      mask_in  = mask_ff;

      if (in_hdr) begin
         if (pos_ff == 16'd0) begin
            ver_in = data_byte[7:4] == 4'(IP_VERSION);
         end
         if (!pos_ff[0]) begin
            hi_in = data_byte;
         end else begin
            sum_in = word_sum[15:0] + {15'b0, word_sum[16]};
         end
         if (pos_ff == 16'd2) begin
            tlen_in = {data_byte, 8'h00};
         end else if (pos_ff == 16'd3) begin
            tlen_in = {tlen_ff[15:8], data_byte};
         end else if (pos_ff == 16'd9) begin
            proto_in = data_byte;
         end
         if (pos_ff >= 16'd16) begin
            dest_in = (pos_ff == 16'd16) ? dest_eq : (dest_ff & dest_eq);
         end
         if (pos_ff == HDR_LEN - 16'd1) begin
            mask_in = new_mask;
         end
      end

      hdr_ok     = ver_ff && dest_ff && (sum_ff == 16'hFFFF) && (tlen_ff >= HDR_LEN);
      is_payload = !in_hdr && hdr_ok && (mask_ff != '0) && (pos_ff < tlen_ff);

      count = {1'b0, pos_ff} + 17'd1;
      if (count < 17'(HEADER_BYTES))          status = ST_TOO_SHORT;
      else if (!ver_in)                       status = ST_BAD_VERSION;
      else if (!dest_in)                      status = ST_NOT_LOCAL;
      else if (sum_in != 16'hFFFF)            status = ST_BAD_CHECKSUM;
      else if (tlen_in < HDR_LEN)             status = ST_BAD_LENGTH;
      else if (count < {1'b0, tlen_in})       status = ST_TRUNCATED;
      else if (mask_in == '0)                 status = ST_NO_HANDLER;
      else                                    status = ST_DELIVERED;

      pay_res.kind         = KIND_PAYLOAD;
      pay_res.payload_byte = data_byte;
      pay_res.handler_mask = mask_ff;
      pay_res.payload_last = count == {1'b0, tlen_ff};
      pay_res.status       = ST_DELIVERED;

      stat_res.kind         = KIND_STATUS;
      stat_res.payload_byte = 8'h00;
      stat_res.handler_mask = mask_in;
      stat_res.payload_last = 1'b0;
      stat_res.status       = status;

      push.first_valid  = in_take && (is_payload || frame_last);
      push.second_valid = in_take && is_payload && frame_last;
      push.first        = is_payload ? pay_res : stat_res;
      push.second       = stat_res;

      if (in_take) begin
         if (frame_last) begin
            pos_in   = '0;
            sum_in   = '0;
            hi_in    = '0;
            tlen_in  = '0;
            proto_in = '0;
            ver_in   = 1'b0;
            dest_in  = 1'b0;
            mask_in  = '0;
         end else if (pos_ff < POS_MAX) begin
            pos_in = pos_ff + 16'd1;
         end
      end else begin
         pos_in   = pos_ff;
         sum_in   = sum_ff;
         hi_in    = hi_ff;
         tlen_in  = tlen_ff;
         proto_in = proto_ff;
         ver_in   = ver_ff;
         dest_in  = dest_ff;
         mask_in  = mask_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         sum_ff   <= '0;
         hi_ff    <= '0;
         tlen_ff  <= '0;
         proto_ff <= '0;
         ver_ff   <= 1'b0;
         dest_ff  <= 1'b0;
         mask_ff  <= '0;
      end else begin
         pos_ff   <= pos_in;
         sum_ff   <= sum_in;
         hi_ff    <= hi_in;
         tlen_ff  <= tlen_in;
         proto_ff <= proto_in;
         ver_ff   <= ver_in;
         dest_ff  <= dest_in;
         mask_ff  <= mask_in;
      end
   end

`ifndef SYNTHESIS
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      push.second_valid |-> push.first_valid && push.first.kind == KIND_PAYLOAD
                            && push.second.kind == KIND_STATUS)
      else $error("two results not ordered payload then status");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      in_take && frame_last |=> pos_ff == 16'd0 && mask_ff == '0)
      else $error("frame state not cleared after frame end");

   a_payload_has_handler: assert property (@(posedge clock) disable iff (reset)
      push.first_valid && push.first.kind == KIND_PAYLOAD |->
         push.first.handler_mask != '0 && !in_hdr)
      else $error("payload item without handler or inside header");
`endif

endmodule

// ===== rtl/ipv4rf_outq.sv =====
module ipv4rf_outq
   import ipv4rf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   output logic       room,
   output logic       out_valid,
   input  logic       out_take,
   output result_type out_res
);

   result_type        q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in;
   logic [QPTR_W-1:0] rd_ff, rd_in;
   logic [QPTR_W:0]   cnt_ff, cnt_in;
   logic [QPTR_W:0]   push_n;
   logic [QPTR_W-1:0] wr_next;

   always_comb begin
      push_n  = (QPTR_W+1)'(push.first_valid) + (QPTR_W+1)'(push.second_valid);
      wr_next = wr_ff + QPTR_W'(1);
      wr_in   = wr_ff + push_n[QPTR_W-1:0];
      rd_in   = out_take ? rd_ff + QPTR_W'(1) : rd_ff;
      cnt_in  = cnt_ff + push_n - (QPTR_W+1)'(out_take);
      // room for a full pair of results
      room      = cnt_ff <= (QPTR_W+1)'(QUEUE_DEPTH - 2);
      out_valid = cnt_ff != '0;
      out_res   = q_ff[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         q_ff[wr_ff] <= push.first;
      end
      if (push.second_valid) begin
         q_ff[wr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import ipv4rf_pkg::*;

   localparam int LONG_HOLD     = 300;
   localparam int DRAIN_CYCLES  = 4;
   localparam int RANDOM_ITEMS  = 750;
   localparam int RANDOM_PHASES = 6;
   localparam int MAX_REPORTS   = 40;
   localparam logic [1:0] CSR_RESERVED_IDX = 2'd3;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [7:0]               req_data_byte;
   logic                     req_frame_last;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic                     rsp_kind;
   logic [7:0]               rsp_payload_byte;
   logic [HANDLER_SLOTS-1:0] rsp_handler_mask;
   logic                     rsp_payload_last;
   logic [2:0]               rsp_status;
   logic                     csr_write;
   logic [1:0]               csr_index;
   logic [31:0]              csr_data;

   ipv4_receive_filter dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_frame_last   (req_frame_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_handler_mask (rsp_handler_mask),
      .rsp_payload_last (rsp_payload_last),
      .rsp_status       (rsp_status),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Filter predictor: register copy and per-frame header state
   // ------------------------------------------------------------------
   logic [31:0] loc_addr;
   logic [31:0] proto_table;
   logic [2:0]  slot_count;

   int unsigned pos;
   logic [16:0] hdr_sum;
   logic [7:0]  hi_byte;
   logic [15:0] tot_len_seen;
   logic [7:0]  proto_seen;
   logic        ver_ok;
   logic        dst_ok;
   logic [3:0]  slot_mask;

   result_type pending_results[$];
   bit         typed_valid = 1'b0;
   status_type typed_status;
   int         mismatches = 0;

   logic [7:0] frame_buf[$];
   bit sender_pauses   = 1'b1;
   bit receiver_pauses = 1'b1;
   bit long_hold_req   = 1'b0;
   int phase_items;

   function automatic void clear_frame();
      pos          = 0;
      hdr_sum      = '0;
      hi_byte      = '0;
      tot_len_seen = '0;
      proto_seen   = '0;
      ver_ok       = 1'b0;
      dst_ok       = 1'b0;
      slot_mask    = '0;
   endfunction

   function automatic logic [3:0] matching_slots();
      int n;
      logic [3:0] m;
      n = (slot_count > HANDLER_SLOTS) ? HANDLER_SLOTS : slot_count;
      m = '0;
      for (int i = 0; i < n; i++)
         if (proto_table[8*i +: 8] == proto_seen) m[i] = 1'b1;
      return m;
   endfunction

   function automatic void predict_filter_results(logic [7:0] b, logic last);
      logic [16:0] s;
      logic        eq;
      int unsigned cnt;
      status_type  st;
      result_type  r;
      if (pos < HEADER_BYTES) begin
         if (pos == 0) ver_ok = (b[7:4] == IP_VERSION);
         if (pos[0] == 1'b0) begin
            hi_byte = b;
         end else begin
            s = hdr_sum + {1'b0, hi_byte, b};
            hdr_sum = {1'b0, s[15:0]} + {16'b0, s[16]};
         end
         case (pos)
            2: tot_len_seen = {b, 8'h00};
            3: tot_len_seen[7:0] = b;
            9: proto_seen = b;
            default: ;
         endcase
         if (pos >= 16) begin
            eq = (loc_addr[8*(19-pos) +: 8] == b);
            dst_ok = (pos == 16) ? eq : (dst_ok & eq);
         end
         if (pos == HEADER_BYTES - 1) slot_mask = matching_slots();
      end else if (ver_ok && dst_ok && hdr_sum == 17'hFFFF && tot_len_seen >= HEADER_BYTES
                   && slot_mask != 0 && pos < tot_len_seen) begin
         r.kind         = KIND_PAYLOAD;
         r.payload_byte = b;
         r.handler_mask = slot_mask;
         r.payload_last = (pos + 1 == tot_len_seen);
         r.status       = ST_DELIVERED;
         pending_results.push_back(r);
      end

      if (last) begin
         cnt = pos + 1;
         if (cnt < HEADER_BYTES)              st = ST_TOO_SHORT;
         else if (!ver_ok)                    st = ST_BAD_VERSION;
         else if (!dst_ok)                    st = ST_NOT_LOCAL;
         else if (hdr_sum != 17'hFFFF)        st = ST_BAD_CHECKSUM;
         else if (tot_len_seen < HEADER_BYTES) st = ST_BAD_LENGTH;
         else if (cnt < tot_len_seen)         st = ST_TRUNCATED;
         else if (slot_mask == 0)             st = ST_NO_HANDLER;
         else                                 st = ST_DELIVERED;
         if (typed_valid) st = typed_status;
         r.kind         = KIND_STATUS;
         r.payload_byte = 8'h00;
         r.handler_mask = slot_mask;
         r.payload_last = 1'b0;
         r.status       = st;
         pending_results.push_back(r);
         clear_frame();
      end else if (pos < 16'hFFFF) begin
         pos++;
      end
   endfunction

   // ------------------------------------------------------------------
   // Frame construction and driving
   // ------------------------------------------------------------------
   function automatic void build_frame(logic [7:0] ver, int tot_len, logic [7:0] prot,
                                       logic [31:0] dst, bit csum_good, int frame_len);
      logic [7:0]  hdr[20];
      logic [16:0] s;
      logic [15:0] ck;
      frame_buf.delete();
      for (int i = 0; i < 20; i++) hdr[i] = 8'($urandom);
      hdr[0]  = ver;
      hdr[2]  = tot_len[15:8];
      hdr[3]  = tot_len[7:0];
      hdr[9]  = prot;
      hdr[10] = 8'h00;
      hdr[11] = 8'h00;
      {hdr[16], hdr[17], hdr[18], hdr[19]} = dst;
      s = '0;
      for (int i = 0; i < 20; i += 2) begin
         s = s + {1'b0, hdr[i], hdr[i+1]};
         s = {1'b0, s[15:0]} + {16'b0, s[16]};
      end
      ck = ~s[15:0];
      if (!csum_good) ck ^= 16'h0001;
      hdr[10] = ck[15:8];
      hdr[11] = ck[7:0];
      for (int i = 0; i < frame_len; i++)
         frame_buf.push_back((i < 20) ? hdr[i] : 8'($urandom));
   endfunction

   // sends frame_buf[from_idx .. to_idx-1]; entered and left at a falling edge
   task automatic send_range(int from_idx, int to_idx);
      int gap;
      for (int i = from_idx; i < to_idx; i++) begin
         gap = sender_pauses ? $urandom_range(0, 13) : 0;
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_valid      = 1'b1;
         req_data_byte  = frame_buf[i];
         req_frame_last = (i == frame_buf.size() - 1);
         do @(posedge clock); while (req_stall);
         predict_filter_results(req_data_byte, req_frame_last);
         @(negedge clock);
      end
   endtask

   task automatic settle();
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] value);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data  = value;
      @(negedge clock);
      csr_write = 1'b0;
      case (idx)
         CSR_LOCAL_ADDR:     loc_addr    = value;
         CSR_HANDLER_PROTOS: proto_table = value;
         CSR_HANDLER_COUNT:  slot_count  = value[2:0];
         default: ;
      endcase
   endtask

   task automatic send_random_frame();
      int pick;
      int tot_len;
      int flen;
      int slot;
      logic [7:0]  ver;
      logic [7:0]  prot;
      logic [31:0] dst;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         // noise: random bytes with a random frame end
         frame_buf.delete();
         flen = $urandom_range(1, 40);
         repeat (flen) frame_buf.push_back(8'($urandom));
      end else begin
         ver = 8'($urandom);
         if ($urandom_range(0, 99) < 92) ver[7:4] = 4'(IP_VERSION);
         dst = ($urandom_range(0, 99) < 90) ? loc_addr : 32'($urandom);
         slot = $urandom_range(0, 3);
         prot = ($urandom_range(0, 99) < 85) ? proto_table[8*slot +: 8] : 8'($urandom);
         pick = $urandom_range(0, 99);
         if (pick < 6)       tot_len = $urandom_range(0, 19);
         else if (pick < 12) tot_len = $urandom_range(45, 16'hFFFF);
         else                tot_len = $urandom_range(20, 44);
         pick = $urandom_range(0, 99);
         if (tot_len < 20 || tot_len > 44) flen = $urandom_range(20, 50);
         else if (pick < 80)               flen = tot_len;
         else if (pick < 88)               flen = tot_len + $urandom_range(1, 8);
         else if (pick < 95)               flen = $urandom_range(20, tot_len);
         else                              flen = $urandom_range(1, 19);
         build_frame(ver, tot_len, prot, dst, $urandom_range(0, 99) < 92, flen);
      end
      send_range(0, frame_buf.size());
      phase_items += frame_buf.size();
   endtask

   // ------------------------------------------------------------------
   // Result side: stall driver and checker
   // ------------------------------------------------------------------
   initial begin
      int hold;
      rsp_stall = 1'b0;
      forever begin
         hold = receiver_pauses ? $urandom_range(0, 13) : 0;
         if (long_hold_req) begin
            hold = LONG_HOLD;
            long_hold_req = 1'b0;
         end
         if (hold > 0) begin
            rsp_stall = 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: unexpected item, expected none actual kind %0d status %0d",
                        $time, rsp_kind, rsp_status);
         end else begin
            want = pending_results.pop_front();
            check_field("kind", 8'(want.kind), 8'(rsp_kind));
            check_field("payload_byte", want.payload_byte, rsp_payload_byte);
            check_field("handler_mask", 8'(want.handler_mask), 8'(rsp_handler_mask));
            check_field("payload_last", 8'(want.payload_last), 8'(rsp_payload_last));
            check_field("status", 8'(want.status), 8'(rsp_status));
         end
      end
   end

   // ------------------------------------------------------------------
   // Directed frames, run with local 192.168.10.1 and slots 11/06/01/06
   // ------------------------------------------------------------------
   typedef struct {
      logic [7:0]  ver_ihl;
      int          tot_len;
      logic [7:0]  prot;
      logic [31:0] dst_flip;
      bit          csum_good;
      int          frame_len;
      bit          fixed;
      status_type  status;
   } header_case_type;

   header_case_type directed_cases[17] = '{
      '{8'h45, 28,    8'h11, 32'h0,         1'b1, 28, 1'b1, ST_DELIVERED},
      '{8'h45, 20,    8'h06, 32'h0,         1'b1, 20, 1'b1, ST_DELIVERED},
      '{8'h4F, 24,    8'h01, 32'h0,         1'b1, 40, 1'b1, ST_DELIVERED},
      '{8'h45, 28,    8'h11, 32'h0,         1'b1, 1,  1'b1, ST_TOO_SHORT},
      '{8'h45, 28,    8'h11, 32'h0,         1'b1, 19, 1'b1, ST_TOO_SHORT},
      '{8'h65, 28,    8'h11, 32'h0,         1'b1, 28, 1'b1, ST_BAD_VERSION},
      '{8'hFF, 28,    8'h11, 32'hFFFF_FFFF, 1'b0, 28, 1'b1, ST_BAD_VERSION},
      '{8'h45, 28,    8'h11, 32'h8000_0000, 1'b1, 28, 1'b1, ST_NOT_LOCAL},
      '{8'h45, 28,    8'h11, 32'h0000_0001, 1'b0, 28, 1'b1, ST_NOT_LOCAL},
      '{8'h45, 28,    8'h11, 32'h0,         1'b0, 28, 1'b1, ST_BAD_CHECKSUM},
      '{8'h45, 19,    8'h11, 32'h0,         1'b1, 28, 1'b1, ST_BAD_LENGTH},
      '{8'h45, 0,     8'h11, 32'h0,         1'b1, 20, 1'b1, ST_BAD_LENGTH},
      '{8'h45, 40,    8'h06, 32'h0,         1'b1, 30, 1'b1, ST_TRUNCATED},
      '{8'h45, 65535, 8'h11, 32'h0,         1'b1, 21, 1'b1, ST_TRUNCATED},
      '{8'h45, 28,    8'hFF, 32'h0,         1'b1, 28, 1'b1, ST_NO_HANDLER},
      '{8'h45, 28,    8'h00, 32'h0,         1'b1, 28, 1'b0, ST_DELIVERED},
      '{8'h40, 24,    8'h06, 32'h0,         1'b1, 24, 1'b0, ST_DELIVERED}
   };

   initial begin
      logic [31:0] cfg_word;
      logic [2:0]  cfg_count;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data_byte  = '0;
      req_frame_last = 1'b0;
      csr_write      = 1'b0;
      csr_index      = '0;
      csr_data       = '0;
      loc_addr       = '0;
      proto_table    = '0;
      slot_count     = '0;
      clear_frame();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      repeat (DRAIN_CYCLES) @(negedge clock);

      // directed part
      write_reg(CSR_LOCAL_ADDR, 32'hC0A8_0A01);
      write_reg(CSR_HANDLER_PROTOS, 32'h0601_0611);
      write_reg(CSR_HANDLER_COUNT, 32'hFFFF_FFF4);
      write_reg(CSR_RESERVED_IDX, 32'hA5A5_5A5A);
      foreach (directed_cases[i]) begin
         build_frame(directed_cases[i].ver_ihl, directed_cases[i].tot_len,
                     directed_cases[i].prot, loc_addr ^ directed_cases[i].dst_flip,
                     directed_cases[i].csum_good, directed_cases[i].frame_len);
         typed_valid  = directed_cases[i].fixed;
         typed_status = directed_cases[i].status;
         send_range(0, frame_buf.size());
         typed_valid = 1'b0;
      end

      // handler writes mid-frame: before the header end they count, after it not
      build_frame(8'h45, 30, 8'h01, loc_addr, 1'b1, 30);
      send_range(0, 10);
      settle();
      write_reg(CSR_HANDLER_PROTOS, 32'h0602_0601);
      send_range(10, 24);
      settle();
      write_reg(CSR_HANDLER_COUNT, 32'd1);
      send_range(24, 30);

      // random part
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         settle();
         case (ph)
            0: begin
               write_reg(CSR_LOCAL_ADDR, 32'h0);
               write_reg(CSR_HANDLER_PROTOS, 32'h0);
               cfg_count = 3'd0;
            end
            1: begin
               write_reg(CSR_LOCAL_ADDR, 32'hFFFF_FFFF);
               write_reg(CSR_HANDLER_PROTOS, 32'hFFFF_FFFF);
               cfg_count = 3'd7;
            end
            default: begin
               write_reg(CSR_LOCAL_ADDR, $urandom);
               write_reg(CSR_HANDLER_PROTOS, $urandom);
               cfg_count = (ph == 3) ? 3'd4 :
                           (ph == 5) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
            end
         endcase
         cfg_word = $urandom;
         cfg_word[2:0] = cfg_count;
         write_reg(CSR_HANDLER_COUNT, cfg_word);
         if (ph % 2 == 1) write_reg(CSR_RESERVED_IDX, $urandom);
         sender_pauses   = (ph == 0 || ph == 2 || ph == 5);
         receiver_pauses = (ph == 0 || ph == 1 || ph == 3 || ph == 5);
         // receiver sits on its output while frames keep coming
         if (ph == 3) long_hold_req = 1'b1;
         phase_items = 0;
         while (phase_items < RANDOM_ITEMS / RANDOM_PHASES) send_random_frame();
      end

      req_valid = 1'b0;
      for (int n = 0; n < 10000 && pending_results.size() != 0; n++) @(negedge clock);
      if (pending_results.size() != 0) begin
         mismatches++;
         $display("%0t: %0d expected items never arrived", $time, pending_results.size());
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #1_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
